FILE: rtl/core/dfs_pkg.sv
package dfs_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_ADDR_W-1:0] {
      ADDR_RADIUS       = 4'h0,
      ADDR_PEAK_SCALE   = 4'h4,
      ADDR_CURVE_SELECT = 4'h8
   } csr_addr_type;

   typedef enum logic [1:0] {
      CURVE_GAUSS  = 2'd0,
      CURVE_CUBIC  = 2'd1,
      CURVE_COSINE = 2'd2,
      CURVE_LINEAR = 2'd3
   } curve_type;

   localparam logic [31:0] RADIUS_RESET = 32'd0;
   localparam logic [15:0] PEAK_RESET   = 16'd4096;
   localparam logic [15:0] SCALE_ONE    = 16'd4096;
   localparam logic [16:0] WEIGHT_ONE   = 17'd65536;

   localparam longint Q30_ONE     = 64'sd1073741824;
   localparam longint Q30_HALF_PI = 64'sd1686629713;

   // side information that rides along with each item
   typedef struct packed {
      logic active;
      logic final_icon;
   } tag_type;

   function automatic logic [16:0] q30_to_q16(longint v);
      longint r;
      begin
         r = (v < 0) ? 64'sd0 : v;
         r = (r + 64'sd8192) >>> 14;
         if (r > 64'sd65536) r = 64'sd65536;
         return r[16:0];
      end
   endfunction

   // quotient of two nonnegative values, only used while the tables are built
   function automatic longint quot(longint num, longint den);
      longint q;
      longint r;
      begin
         q = 0;
         r = 0;
         for (int bit_pos = 62; bit_pos >= 0; bit_pos--) begin
            r = (r <<< 1) | ((num >>> bit_pos) & 64'sd1);
            if (r >= den) begin
               r = r - den;
               q = q | (64'sd1 <<< bit_pos);
            end
         end
         return q;
      end
   endfunction

   function automatic longint exp_neg_q30(longint x);
      longint y;
      longint term;
      longint sum;
      begin
         y    = x >>> 3;
         term = Q30_ONE;
         sum  = Q30_ONE;
         for (int n = 1; n <= 14; n++) begin
            term = quot((term * y) >>> 30, longint'(n));
            if (n % 2 == 1) sum = sum - term;
            else sum = sum + term;
         end
         if (sum < 0) sum = 0;
         for (int n = 0; n < 3; n++) sum = (sum * sum + (64'sd1 <<< 29)) >>> 30;
         return sum;
      end
   endfunction

   function automatic longint cos_q30(longint t);
      longint t2;
      longint term;
      longint sum;
      begin
         t2   = (t * t) >>> 30;
         term = Q30_ONE;
         sum  = Q30_ONE;
         for (int n = 1; n <= 12; n++) begin
            term = quot((term * t2) >>> 30, longint'((2 * n - 1) * (2 * n)));
            if (n % 2 == 1) sum = sum - term;
            else sum = sum + term;
         end
         if (sum < 0) sum = 0;
         if (sum > Q30_ONE) sum = Q30_ONE;
         return sum;
      end
   endfunction

   // u is the sample position in Q30
   function automatic logic [16:0] gauss_weight(longint u);
      longint u2;
      longint x;
      begin
         u2 = (u * u) >>> 30;
         x  = (u2 * 25) >>> 3;
         return q30_to_q16(exp_neg_q30(x));
      end
   endfunction

   function automatic logic [16:0] cosine_weight(longint u);
      longint c;
      begin
         c = cos_q30((u * Q30_HALF_PI) >>> 30);
         return q30_to_q16((c * c + (64'sd1 <<< 29)) >>> 30);
      end
   endfunction

endpackage

FILE: rtl/core/dfs_req_if.sv
interface dfs_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] cursor_pos;
   logic signed [31:0] icon_pos;
   logic               final_icon;

   modport source (output valid, output cursor_pos, output icon_pos, output final_icon,
                   input ready);
   modport sink (input valid, input cursor_pos, input icon_pos, input final_icon,
                 output ready);
endinterface

FILE: rtl/core/dfs_rsp_if.sv
interface dfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] icon_scale;
   logic        final_scale;

   modport source (output valid, output icon_scale, output final_scale, input ready);
   modport sink (input valid, input icon_scale, input final_scale, output ready);
endinterface

FILE: rtl/core/dfs_divider.sv
// restoring divider, one quotient bit per stage: q = floor(d * 2^16 / r), d < r
module dfs_divider (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [31:0]      in_d,
   input  dfs_pkg::tag_type in_tag,
   input  logic [31:0]      radius,
   output logic             out_valid,
   output logic [15:0]      out_q,
   output dfs_pkg::tag_type out_tag
);
   import dfs_pkg::*;

   localparam int STAGES = 16;

   logic [31:0]     rem_ff   [STAGES];
   logic [15:0]     quo_ff   [STAGES];
   logic            valid_ff [STAGES];
   tag_type         tag_ff   [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [31:0] rem_src;
      logic [15:0] quo_src;
      logic        valid_src;
      tag_type     tag_src;
      logic [32:0] rem2;
      logic        ge;
      logic [32:0] rem_sub;

      if (s == 0) begin : g_first
         assign rem_src   = in_d;
         assign quo_src   = 16'd0;
         assign valid_src = in_valid;
         assign tag_src   = in_tag;
      end else begin : g_next
         assign rem_src   = rem_ff[s-1];
         assign quo_src   = quo_ff[s-1];
         assign valid_src = valid_ff[s-1];
         assign tag_src   = tag_ff[s-1];
      end

      assign rem2    = {rem_src, 1'b0};
      assign ge      = rem2 >= {1'b0, radius};
      assign rem_sub = rem2 - {1'b0, radius};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_src;
         end
         if (en) begin
            rem_ff[s] <= ge ? rem_sub[31:0] : rem2[31:0];
            quo_ff[s] <= {quo_src[14:0], ge};
            tag_ff[s] <= tag_src;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_q     = quo_ff[STAGES-1];
   assign out_tag   = tag_ff[STAGES-1];
endmodule

FILE: rtl/core/dfs_curve.sv
module dfs_curve #(
   parameter int CURVE_TABLE_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [15:0]      in_u,
   input  dfs_pkg::tag_type in_tag,
   input  logic [1:0]       curve_select,
   input  logic [15:0]      peak_scale,
   output logic             out_valid,
   output logic [15:0]      out_scale,
   output logic             out_final
);
   import dfs_pkg::*;

   localparam int IDX_W = $clog2(CURVE_TABLE_DEPTH + 1);
   localparam int POS_W = 17 + $clog2(CURVE_TABLE_DEPTH);
   localparam int RAW_W = POS_W - 16;

   logic [16:0] gauss_tab [CURVE_TABLE_DEPTH+1];
   logic [16:0] cos_tab   [CURVE_TABLE_DEPTH+1];

   for (genvar k = 0; k <= CURVE_TABLE_DEPTH; k++) begin : g_tab
      localparam longint USAMP = (longint'(k) <<< 30) / CURVE_TABLE_DEPTH;
      localparam logic [16:0] GAUSS_W  = gauss_weight(USAMP);
      localparam logic [16:0] COSINE_W = cosine_weight(USAMP);
      assign gauss_tab[k] = GAUSS_W;
      assign cos_tab[k]   = COSINE_W;
   end

   // stage 1: table read and first cubic product
   logic [POS_W-1:0] pos;
   logic [RAW_W-1:0] idx_raw;
   logic [IDX_W-1:0] idx;
   logic [IDX_W-1:0] idx_next;
   logic [16:0]      ta;
   logic [16:0]      tb;
   logic [16:0]      one_minus_u;

   assign pos      = POS_W'(in_u) * POS_W'(CURVE_TABLE_DEPTH);
   assign idx_raw  = pos[POS_W-1:16];
   assign idx      = (idx_raw >= RAW_W'(CURVE_TABLE_DEPTH - 1)) ?
                     IDX_W'(CURVE_TABLE_DEPTH - 1) : IDX_W'(idx_raw);
   assign idx_next = idx + IDX_W'(1);
   assign one_minus_u = WEIGHT_ONE - {1'b0, in_u};

   always_comb begin
      if (curve_select == CURVE_GAUSS) begin
         ta = gauss_tab[idx];
         tb = gauss_tab[idx_next];
      end else begin
         ta = cos_tab[idx];
         tb = cos_tab[idx_next];
      end
   end

   logic        s1_valid_ff;
   tag_type     s1_tag_ff;
   logic [16:0] s1_a_ff;
   logic [16:0] s1_span_ff;
   logic        s1_down_ff;
   logic [15:0] s1_f_ff;
   logic [33:0] s1_sq_ff;
   logic [17:0] s1_m_ff;
   logic [16:0] s1_lin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
      if (en) begin
         s1_tag_ff  <= in_tag;
         s1_a_ff    <= ta;
         s1_down_ff <= tb <= ta;
         s1_span_ff <= (tb <= ta) ? ta - tb : tb - ta;
         s1_f_ff    <= pos[15:0];
         s1_sq_ff   <= 34'(one_minus_u) * 34'(one_minus_u);
         s1_m_ff    <= 18'd65536 + {1'b0, in_u, 1'b0};
         s1_lin_ff  <= one_minus_u;
      end
   end

   // stage 2: interpolation and second cubic product
   logic [32:0] interp_prod;
   logic [16:0] interp_w;

   assign interp_prod = 33'(s1_span_ff) * 33'(s1_f_ff);
   assign interp_w    = s1_down_ff ? s1_a_ff - interp_prod[32:16] :
                                     s1_a_ff + interp_prod[32:16];

   logic        s2_valid_ff;
   tag_type     s2_tag_ff;
   logic [16:0] s2_tab_ff;
   logic [51:0] s2_cub_ff;
   logic [16:0] s2_lin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_tag_ff <= s1_tag_ff;
         s2_tab_ff <= interp_w;
         s2_cub_ff <= 52'(s1_sq_ff) * 52'(s1_m_ff);
         s2_lin_ff <= s1_lin_ff;
      end
   end

   // stage 3: weight select
   logic [51:0] cub_round;
   logic [19:0] cub_w;
   logic [19:0] w_sel;

   assign cub_round = s2_cub_ff + (52'd1 << 31);
   assign cub_w     = cub_round[51:32];

   always_comb begin
      case (curve_select)
         CURVE_CUBIC:  w_sel = cub_w;
         CURVE_LINEAR: w_sel = {3'd0, s2_lin_ff};
         default:      w_sel = {3'd0, s2_tab_ff};
      endcase
   end

   logic        s3_valid_ff;
   logic        s3_final_ff;
   logic [16:0] s3_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (en) begin
         s3_final_ff <= s2_tag_ff.final_icon;
         // out of range or zero radius gives zero weight
         if (!s2_tag_ff.active) s3_w_ff <= 17'd0;
         else if (w_sel > 20'(WEIGHT_ONE)) s3_w_ff <= WEIGHT_ONE;
         else s3_w_ff <= w_sel[16:0];
      end
   end

   // stage 4: scale, output register
   logic [15:0] range_q;
   logic [32:0] scale_prod;
   logic [17:0] scale_sum;

   assign range_q    = (peak_scale > SCALE_ONE) ? peak_scale - SCALE_ONE : 16'd0;
   assign scale_prod = 33'(range_q) * 33'(s3_w_ff) + 33'd32768;
   assign scale_sum  = 18'(SCALE_ONE) + {1'b0, scale_prod[32:16]};

   logic        s4_valid_ff;
   logic        s4_final_ff;
   logic [15:0] s4_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (en) begin
         s4_final_ff <= s3_final_ff;
         s4_scale_ff <= (scale_sum > 18'd65535) ? 16'hFFFF : scale_sum[15:0];
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_scale = s4_scale_ff;
   assign out_final = s4_final_ff;
endmodule

FILE: rtl/core/distance_falloff_scale.sv
// Dock magnification falloff: one icon scale per input item, one item per clock when the
// result side keeps up. One stage forms |cursor - icon| and the range check, a 16-stage
// restoring divider forms u = d / radius one quotient bit per stage, and four stages do
// the curve table read, interpolation, weight select and the final Q4.12 scale. The
// whole pipeline stalls as one when the result is not taken.
// Registers (APB, byte address): 0x0 radius (Q16.16), 0x4 peak_scale (Q4.12),
// 0x8 curve_select (0 Gaussian, 1 cubic, 2 raised cosine, 3 linear). Write them only
// while no items are in flight.
module distance_falloff_scale #(
   parameter int CURVE_TABLE_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   dfs_req_if.sink                          req_chan,
   dfs_rsp_if.source                        rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dfs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [dfs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dfs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import dfs_pkg::*;

   logic [31:0] radius_ff;
   logic [15:0] peak_ff;
   logic [1:0]  curve_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         peak_ff   <= PEAK_RESET;
         curve_ff  <= CURVE_COSINE;
      end else if (csr_wr) begin
         unique case (csr_paddr)
            ADDR_RADIUS:       radius_ff <= csr_pwdata;
            ADDR_PEAK_SCALE:   peak_ff   <= csr_pwdata[15:0];
            ADDR_CURVE_SELECT: curve_ff  <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         ADDR_RADIUS:       csr_prdata = radius_ff;
         ADDR_PEAK_SCALE:   csr_prdata = {16'd0, peak_ff};
         ADDR_CURVE_SELECT: csr_prdata = {30'd0, curve_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // pipeline moves whenever the output register is free or being drained
   logic en;
   logic out_valid;

   assign en             = !out_valid || rsp_chan.ready;
   assign req_chan.ready = en;

   logic signed [32:0] diff;
   logic        [32:0] abs_diff;
   logic               in_range;

   assign diff     = {req_chan.cursor_pos[31], req_chan.cursor_pos}
                   - {req_chan.icon_pos[31], req_chan.icon_pos};
   assign abs_diff = diff[32] ? 33'(-diff) : 33'(diff);
   assign in_range = (radius_ff != 32'd0) && (abs_diff < {1'b0, radius_ff});

   logic        f_valid_ff;
   logic [31:0] f_d_ff;
   tag_type     f_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= req_chan.valid;
      end
      if (en) begin
         f_d_ff              <= in_range ? abs_diff[31:0] : 32'd0;
         f_tag_ff.active     <= in_range;
         f_tag_ff.final_icon <= req_chan.final_icon;
      end
   end

   logic        div_valid;
   logic [15:0] div_q;
   tag_type     div_tag;

   dfs_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid_ff),
      .in_d      (f_d_ff),
      .in_tag    (f_tag_ff),
      .radius    (radius_ff),
      .out_valid (div_valid),
      .out_q     (div_q),
      .out_tag   (div_tag)
   );

   dfs_curve #(
      .CURVE_TABLE_DEPTH (CURVE_TABLE_DEPTH)
   ) u_curve (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (div_valid),
      .in_u         (div_q),
      .in_tag       (div_tag),
      .curve_select (curve_ff),
      .peak_scale   (peak_ff),
      .out_valid    (out_valid),
      .out_scale    (rsp_chan.icon_scale),
      .out_final    (rsp_chan.final_scale)
   );

   assign rsp_chan.valid = out_valid;
endmodule

FILE: rtl/core/dfs_checker.sv
module dfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] icon_scale,
   input logic        final_scale
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(icon_scale) && $stable(final_scale))
      else $error("result changed while stalled");

   a_scale_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> icon_scale >= 16'd4096)
      else $error("scale below one");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result present after reset");
endmodule

bind distance_falloff_scale dfs_checker u_dfs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .icon_scale  (rsp_chan.icon_scale),
   .final_scale (rsp_chan.final_scale)
);
